FILE: hw/rtl/vcsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command stream parser package
// Shared types and constants for the sound-log command stream parser.
// ----------------------------------------------------------------------------
package vcsp_pkg;

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_ADDR  = 3'd1,
    PH_DATA  = 3'd2,
    PH_WLOW  = 3'd3,
    PH_WHIGH = 3'd4,
    PH_HALT  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  localparam logic [7:0] CmdHighMask  = 8'hf0;
  localparam logic [7:0] CmdShortWait = 8'h70;
  localparam logic [7:0] CmdLowMask   = 8'h0f;
  localparam logic [7:0] CmdRegWrite  = 8'h54;
  localparam logic [7:0] CmdWait16    = 8'h61;
  localparam logic [7:0] CmdWaitNtsc  = 8'h62;
  localparam logic [7:0] CmdWaitPal   = 8'h63;
  localparam logic [7:0] CmdEnd       = 8'h66;

  localparam logic [15:0] WaitNtscSamples = 16'd735;
  localparam logic [15:0] WaitPalSamples  = 16'd882;

endpackage

FILE: hw/rtl/vgm_command_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command stream parser
// Decodes a sound-log command stream, one byte per transfer, into register
// writes, waits, end-of-stream marks and unsupported-command errors.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per unstalled cycle. Each byte updates a
// small phase register, and the byte that completes a command loads the
// result register, so the result appears in the cycle after that byte's
// transfer. The input is stalled only while the result register holds an
// item that the output side stalls. After an unsupported command the block
// reports it once and then consumes and drops every byte until reset.
module vgm_command_stream_parser_top
  import vcsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  reg_addr_o,
  output logic [7:0]  reg_value_o,
  output logic [15:0] wait_samples_o,
  output logic [15:0] loops_done_o,
  output logic [7:0]  bad_command_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  held_addr_q, held_addr_d;
  logic [7:0]  held_low_q, held_low_d;
  logic [15:0] loop_cnt_q, loop_cnt_d;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  reg_addr_q, reg_addr_d;
  logic [7:0]  reg_value_q, reg_value_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] loops_q, loops_d;
  logic [7:0]  bad_q, bad_d;

  logic        accept;
  logic        emit;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    phase_d     = phase_q;
    held_addr_d = held_addr_q;
    held_low_d  = held_low_q;
    loop_cnt_d  = loop_cnt_q;
    emit        = 1'b0;
    kind_d      = KIND_WAIT;
    reg_addr_d  = '0;
    reg_value_d = '0;
    wait_d      = '0;
    bad_d       = '0;
    case (phase_q)
      PH_CMD: begin
        if ((stream_byte_i & CmdHighMask) == CmdShortWait) begin
          emit   = 1'b1;
          kind_d = KIND_WAIT;
          wait_d = {8'd0, stream_byte_i & CmdLowMask};
        end else begin
          case (stream_byte_i)
            CmdRegWrite: phase_d = PH_ADDR;
            CmdWait16:   phase_d = PH_WLOW;
            CmdWaitNtsc: begin
              emit   = 1'b1;
              kind_d = KIND_WAIT;
              wait_d = WaitNtscSamples;
            end
            CmdWaitPal: begin
              emit   = 1'b1;
              kind_d = KIND_WAIT;
              wait_d = WaitPalSamples;
            end
            CmdEnd: begin
              emit       = 1'b1;
              kind_d     = KIND_END;
              loop_cnt_d = loop_cnt_q + 16'd1;
            end
            default: begin
              emit    = 1'b1;
              kind_d  = KIND_BAD;
              bad_d   = stream_byte_i;
              phase_d = PH_HALT;
            end
          endcase
        end
      end
      PH_ADDR: begin
        held_addr_d = stream_byte_i;
        phase_d     = PH_DATA;
      end
      PH_DATA: begin
        emit        = 1'b1;
        kind_d      = KIND_WRITE;
        reg_addr_d  = held_addr_q;
        reg_value_d = stream_byte_i;
        phase_d     = PH_CMD;
      end
      PH_WLOW: begin
        held_low_d = stream_byte_i;
        phase_d    = PH_WHIGH;
      end
      PH_WHIGH: begin
        emit    = 1'b1;
        kind_d  = KIND_WAIT;
        wait_d  = {stream_byte_i, held_low_q};
        phase_d = PH_CMD;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
    loops_d = loop_cnt_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CMD;
      held_addr_q <= '0;
      held_low_q  <= '0;
      loop_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q     <= phase_d;
        held_addr_q <= held_addr_d;
        held_low_q  <= held_low_d;
        loop_cnt_q  <= loop_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q      <= kind_d;
      reg_addr_q  <= reg_addr_d;
      reg_value_q <= reg_value_d;
      wait_q      <= wait_d;
      loops_q     <= loops_d;
      bad_q       <= bad_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign reg_addr_o     = reg_addr_q;
  assign reg_value_o    = reg_value_q;
  assign wait_samples_o = wait_q;
  assign loops_done_o   = loops_q;
  assign bad_command_o  = bad_q;

endmodule

FILE: hw/rtl/vcsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command stream parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module vcsp_checker
  import vcsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  stream_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  reg_addr_o,
  input logic [7:0]  reg_value_o,
  input logic [15:0] wait_samples_o,
  input logic [15:0] loops_done_o,
  input logic [7:0]  bad_command_o
);

  logic end_xfer;

  assign end_xfer = out_valid_o && !out_stall_i && (kind_o == KIND_END);

  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(stream_byte_i))
    else $error("Stalled input transfer changed.");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(wait_samples_o) && $stable(loops_done_o))
    else $error("Stalled result changed.");

  a_write_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_WRITE) |-> wait_samples_o == 16'd0 &&
      bad_command_o == 8'd0)
    else $error("Register write carries wait or error fields.");

  a_wait_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_WAIT) |-> reg_addr_o == 8'd0 &&
      reg_value_o == 8'd0 && bad_command_o == 8'd0)
    else $error("Wait carries write or error fields.");

  a_loop_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_xfer ##1 end_xfer |-> loops_done_o == $past(loops_done_o) + 16'd1)
    else $error("Back-to-back end marks did not advance the loop count.");

endmodule

bind vgm_command_stream_parser_top vcsp_checker u_vcsp_checker (.*);

FILE: tb/tb_vgm_command_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command stream parser testbench
// Feeds the parser a byte stream and checks every decoded result. A short
// directed sequence covers the field extremes and each command. A random
// section of well-formed commands with arbitrary operands follows. The run
// ends with one unsupported command and trailing bytes that must be dropped.
// Both sides of the block idle and stall at random throughout.
// ----------------------------------------------------------------------------
module tb_vgm_command_stream_parser_top;
  import vcsp_pkg::*;

  localparam int unsigned CycleLimit = 5_000_000;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  addr;
    logic [7:0]  value;
    logic [15:0] samples;
    logic [15:0] loops;
    logic [7:0]  bad;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  stream_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  reg_addr_o;
  logic [7:0]  reg_value_o;
  logic [15:0] wait_samples_o;
  logic [15:0] loops_done_o;
  logic [7:0]  bad_command_o;

  logic [7:0]    pending_bytes[$];
  parse_result_t expected_results[$];
  parse_result_t head_result;

  phase_e      parse_phase = PH_CMD;
  logic [7:0]  held_addr = 8'h00;
  logic [7:0]  held_low = 8'h00;
  logic [15:0] loop_count = 16'h0000;

  logic        in_accepted = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};

  vgm_command_stream_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .reg_addr_o     (reg_addr_o),
    .reg_value_o    (reg_value_o),
    .wait_samples_o (wait_samples_o),
    .loops_done_o   (loops_done_o),
    .bad_command_o  (bad_command_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic parse_stream_byte(input logic [7:0] b);
    parse_result_t r;
    logic          emit;
    r = '0;
    emit = 1'b0;
    case (parse_phase)
      PH_CMD: begin
        if ((b & CmdHighMask) == CmdShortWait) begin
          r.kind = KIND_WAIT;
          r.samples = {8'h00, b & CmdLowMask};
          emit = 1'b1;
        end else begin
          case (b)
            CmdRegWrite: parse_phase = PH_ADDR;
            CmdWait16:   parse_phase = PH_WLOW;
            CmdWaitNtsc: begin
              r.kind = KIND_WAIT;
              r.samples = WaitNtscSamples;
              emit = 1'b1;
            end
            CmdWaitPal: begin
              r.kind = KIND_WAIT;
              r.samples = WaitPalSamples;
              emit = 1'b1;
            end
            CmdEnd: begin
              loop_count = loop_count + 16'd1;
              r.kind = KIND_END;
              emit = 1'b1;
            end
            default: begin
              parse_phase = PH_HALT;
              r.kind = KIND_BAD;
              r.bad = b;
              emit = 1'b1;
            end
          endcase
        end
      end
      PH_ADDR: begin
        held_addr = b;
        parse_phase = PH_DATA;
      end
      PH_DATA: begin
        parse_phase = PH_CMD;
        r.kind = KIND_WRITE;
        r.addr = held_addr;
        r.value = b;
        emit = 1'b1;
      end
      PH_WLOW: begin
        held_low = b;
        parse_phase = PH_WHIGH;
      end
      PH_WHIGH: begin
        parse_phase = PH_CMD;
        r.kind = KIND_WAIT;
        r.samples = {b, held_low};
        emit = 1'b1;
      end
      default: ;
    endcase
    if (emit) begin
      r.loops = loop_count;
      expected_results.push_back(r);
      kind_count[r.kind]++;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_accepted) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        in_valid_i <= 1'b1;
        stream_byte_i <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switches between no stalls, light stalls and heavy stalls.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: kind %0h wait %0h loops %0h", $time,
                   kind_o, wait_samples_o, loops_done_o);
          mismatches++;
        end else begin
          head_result = expected_results.pop_front();
          results_checked++;
          check_field("kind", 16'(head_result.kind), 16'(kind_o));
          check_field("reg_addr", 16'(head_result.addr), 16'(reg_addr_o));
          check_field("reg_value", 16'(head_result.value), 16'(reg_value_o));
          check_field("wait_samples", head_result.samples, wait_samples_o);
          check_field("loops_done", head_result.loops, loops_done_o);
          check_field("bad_command", 16'(head_result.bad), 16'(bad_command_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        parse_stream_byte(stream_byte_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("vgm_command_stream_parser_top regression: fail");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_command();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        push_byte(CmdRegWrite);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end
      3, 4: push_byte(CmdShortWait | 8'($urandom_range(0, 15)));
      5, 6: begin
        push_byte(CmdWait16);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end
      7:       push_byte(CmdWaitNtsc);
      8:       push_byte(CmdWaitPal);
      default: push_byte(CmdEnd);
    endcase
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned random_start;
    logic [7:0]  bad_byte;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_byte(CmdShortWait);
    push_byte(CmdShortWait | CmdLowMask);
    push_byte(CmdRegWrite);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(CmdRegWrite);
    push_byte(8'hff);
    push_byte(8'hff);
    push_byte(CmdWait16);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(CmdWait16);
    push_byte(8'hff);
    push_byte(8'hff);
    push_byte(CmdWait16);
    push_byte(8'h34);
    push_byte(8'h12);
    push_byte(CmdWaitNtsc);
    push_byte(CmdWaitPal);
    push_byte(CmdEnd);
    // Operand bytes that look like commands must not be decoded.
    push_byte(CmdRegWrite);
    push_byte(CmdEnd);
    push_byte(CmdRegWrite);
    push_byte(CmdWait16);
    push_byte(CmdShortWait);
    push_byte(CmdWait16);
    wait_drained();

    random_start = bytes_queued;
    while (bytes_queued - random_start < 1400) begin
      push_command();
      if ($urandom_range(0, 299) == 0) begin
        wait_drained();
      end
    end

    bad_byte = CmdRegWrite;
    while (bad_byte == CmdRegWrite || bad_byte == CmdWait16 || bad_byte == CmdWaitNtsc ||
           bad_byte == CmdWaitPal || bad_byte == CmdEnd ||
           (bad_byte & CmdHighMask) == CmdShortWait) begin
      bad_byte = 8'($urandom_range(0, 255));
    end
    push_byte(bad_byte);
    repeat (20) push_command();
    repeat (20) push_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (10) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Run covered %0d stream bytes and %0d checked results: %0d writes, %0d waits,",
             bytes_taken, results_checked, kind_count[KIND_WRITE], kind_count[KIND_WAIT]);
    $display("%0d end marks with a final loop count of %0d, and %0d unsupported command.",
             kind_count[KIND_END], loop_count, kind_count[KIND_BAD]);
    if (mismatches == 0) begin
      $display("vgm_command_stream_parser_top regression: pass");
    end else begin
      $display("vgm_command_stream_parser_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/vcsp_pkg.sv
hw/rtl/vgm_command_stream_parser_top.sv
hw/rtl/vcsp_checker.sv
tb/tb_vgm_command_stream_parser_top.sv
